// ----- rtl/core/hps_pkg.sv -----
`default_nettype none

package hps_pkg;

   // fixed field widths
   localparam int VERTEX_W    = 16;
   localparam int LIMIT_W     = 7;
   localparam int DIST_OUT_W  = 4;
   localparam int CUBE_BITS_W = 5;
   localparam int CUBE_EXT_W  = CUBE_BITS_W + 1;

   // defaults for the top level parameters
   localparam int MAX_BITS_DEF   = 16;
   localparam int MAX_PROBES_DEF = 64;

   // register file
   localparam int                   CSR_ADDR_W       = 3;
   localparam int                   CSR_DATA_W       = 32;
   localparam logic                 CSR_IDX_CUBE_BITS = 1'b0;
   localparam logic [CUBE_BITS_W-1:0] CUBE_BITS_RESET = 5'd16;

   typedef enum logic {
      HPS_IDLE,
      HPS_RUN
   } hps_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // take a new query
      logic step;   // move the current probe into the output register
   } hps_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;    // output register free or being drained
      logic last_probe;  // current probe ends the query
   } hps_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/hps_req_if.sv -----
`default_nettype none

interface hps_req_if import hps_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] vertex;
   logic [LIMIT_W-1:0]  probe_limit;

   modport source (output valid, output vertex, output probe_limit, input ready);
   modport sink   (input valid, input vertex, input probe_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hps_rsp_if.sv -----
`default_nettype none

interface hps_rsp_if import hps_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [VERTEX_W-1:0]   probe_vertex;
   logic [DIST_OUT_W-1:0] flip_distance;
   logic                  last;

   modport source (output valid, output probe_vertex, output flip_distance,
                   output last, input ready);
   modport sink   (input valid, input probe_vertex, input flip_distance,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hps_ctrl.sv -----
`default_nettype none

module hps_ctrl import hps_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire hps_stat_type stat,
   output hps_cmd_type       cmd
);

   hps_state_type state_ff;
   hps_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HPS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         HPS_IDLE: begin
            if (req_valid) state_in = HPS_RUN;
         end
         HPS_RUN: begin
            if (stat.out_free && stat.last_probe) state_in = HPS_IDLE;
         end
         default: begin
            state_in = HPS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         HPS_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         HPS_RUN: begin
            cmd.step = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/hps_datapath.sv -----
`default_nettype none

module hps_datapath import hps_pkg::*; #(
   parameter int MAX_BITS   = MAX_BITS_DEF,
   parameter int MAX_PROBES = MAX_PROBES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hps_cmd_type            cmd,
   output hps_stat_type                stat,
   input  wire logic [CUBE_BITS_W-1:0] cube_bits,
   input  wire logic [VERTEX_W-1:0]    vertex,
   input  wire logic [LIMIT_W-1:0]     probe_limit,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [VERTEX_W-1:0]         rsp_probe_vertex,
   output logic [DIST_OUT_W-1:0]       rsp_flip_distance,
   output logic                        rsp_last
);

   localparam int W     = MAX_BITS;
   localparam int BW    = $clog2(MAX_BITS + 1);
   localparam int DW    = $clog2(MAX_BITS);
   localparam int CNT_W = $clog2(MAX_PROBES + 1);
   localparam int SH_W  = $clog2(MAX_BITS + 1);

   // query state
   logic [VERTEX_W-1:0] held_ff,   held_in;
   logic [W-1:0]        mask_ff,   mask_in;
   logic [DW-1:0]       dist_ff,   dist_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [BW-1:0]       bits_ff,   bits_in;

   // output register
   logic                  ovalid_ff, ovalid_in;
   logic [VERTEX_W-1:0]   opv_ff,    opv_in;
   logic [DIST_OUT_W-1:0] odist_ff,  odist_in;
   logic                  olast_ff,  olast_in;

   // clamped query parameters
   logic [CUBE_EXT_W-1:0] bits_ext;
   logic [BW-1:0]         bits_eff;
   logic [LIMIT_W-1:0]    lim_eff;
   logic [VERTEX_W-1:0]   vfull;

   // mask sequencing
   logic [W-1:0]   full_w;
   logic [W-1:0]   trail;
   logic [W-1:0]   rest;
   logic [W-1:0]   low_bit;
   logic [W-1:0]   below;
   logic [W-1:0]   blk;
   logic [W-1:0]   next_mask;
   logic [W-1:0]   start_mask;
   logic [SH_W-1:0] shift_n;
   logic [BW-1:0]  dist_inc;
   logic           dist_end;
   logic           last_now;

   always_comb begin
      bits_ext = {1'b0, cube_bits};
      if (bits_ext == '0) begin
         bits_ext = CUBE_EXT_W'(1);
      end else if (bits_ext > CUBE_EXT_W'(MAX_BITS)) begin
         bits_ext = CUBE_EXT_W'(MAX_BITS);
      end
      bits_eff = bits_ext[BW-1:0];

      lim_eff = probe_limit;
      if (lim_eff == '0) begin
         lim_eff = LIMIT_W'(1);
      end else if (lim_eff > LIMIT_W'(MAX_PROBES)) begin
         lim_eff = LIMIT_W'(MAX_PROBES);
      end
   end

   always_comb begin
      for (int i = 0; i < VERTEX_W; i++) begin
         vfull[i] = (i < int'(bits_eff));
      end
   end

   // previous combination of equal weight (descending order):
   // drop the lowest set bit that has a zero below it and pack the
   // trailing ones plus that bit directly beneath its old place
   always_comb begin
      trail    = mask_ff & ~(mask_ff + W'(1));
      rest     = mask_ff & ~trail;
      low_bit  = rest & (~rest + W'(1));
      below    = low_bit - W'(1);
      shift_n  = SH_W'($countones(trail)) + SH_W'(1);
      blk      = below & ~(below >> shift_n);
      next_mask = (rest & ~low_bit) | blk;
      dist_inc = BW'(dist_ff) + BW'(1);
      dist_end = (rest == '0);
      last_now = (remain_ff == '0) || (dist_end && (dist_inc == bits_ff));
   end

   // first mask of the next distance: its top bits inside the cube
   always_comb begin
      for (int i = 0; i < W; i++) begin
         full_w[i]     = (i < int'(bits_ff));
         start_mask[i] = full_w[i] && ((i + int'(dist_inc)) >= int'(bits_ff));
      end
   end

   always_comb begin
      stat.out_free   = !ovalid_ff || rsp_ready;
      stat.last_probe = last_now;
   end

   always_comb begin
      held_in   = held_ff;
      mask_in   = mask_ff;
      dist_in   = dist_ff;
      remain_in = remain_ff;
      bits_in   = bits_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      opv_in    = opv_ff;
      odist_in  = odist_ff;
      olast_in  = olast_ff;

      priority if (cmd.load) begin
         held_in   = vertex & vfull;
         mask_in   = '0;
         dist_in   = '0;
         remain_in = CNT_W'(lim_eff - LIMIT_W'(1));
         bits_in   = bits_eff;
      end else if (cmd.step) begin
         ovalid_in = 1'b1;
         opv_in    = held_ff ^ VERTEX_W'(mask_ff);
         odist_in  = DIST_OUT_W'(dist_ff);
         olast_in  = last_now;
         if (!last_now) begin
            remain_in = remain_ff - CNT_W'(1);
            if (dist_end) begin
               mask_in = start_mask;
               dist_in = dist_inc[DW-1:0];
            end else begin
               mask_in = next_mask;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         mask_ff   <= '0;
         dist_ff   <= '0;
         remain_ff <= '0;
         bits_ff   <= BW'(1);
      end else begin
         ovalid_ff <= ovalid_in;
         mask_ff   <= mask_in;
         dist_ff   <= dist_in;
         remain_ff <= remain_in;
         bits_ff   <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      opv_ff   <= opv_in;
      odist_ff <= odist_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_probe_vertex  = opv_ff;
   assign rsp_flip_distance = odist_ff;
   assign rsp_last          = olast_ff;

   // mask weight always tracks the distance
   a_weight: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == int'(dist_ff))
      else $error("flip mask weight differs from distance");

   // mask never leaves the cube
   a_in_cube: assert property (@(posedge clock) disable iff (reset)
      (mask_ff & ~full_w) == '0)
      else $error("flip mask outside cube");

   // a step always lands a probe in the output register
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> ovalid_ff)
      else $error("step lost a probe");

endmodule

`default_nettype wire

// ----- rtl/core/hamming_probe_sequencer.sv -----
`default_nettype none

// channel   | dir | payload                                   | handshake
// ----------+-----+-------------------------------------------+------------------
// req_chan  | in  | vertex[15:0], probe_limit[6:0]            | valid/ready
// rsp_chan  | out | probe_vertex[15:0], flip_distance[3:0], last | valid/ready
// csr (APB) | in  | cube_bits[4:0] at byte address 0          | psel/penable
//
// A query of n probes (n = max(1, min(probe_limit, MAX_PROBES)), capped by
// 2^cube_bits - 1) is accepted and then issued one probe per cycle
// through the mask sequencer while rsp ready stays high.
// The next item is taken as soon as the final probe sits in the output register.
// Reset: cube_bits returns to 16, sequencer idle, output empty; no clearing pass.
// A low rsp ready stalls the sequencer with the current probe held.

module hamming_probe_sequencer import hps_pkg::*; #(
   parameter int MAX_BITS   = MAX_BITS_DEF,
   parameter int MAX_PROBES = MAX_PROBES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hps_req_if.sink                    req_chan,
   hps_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   hps_cmd_type  cmd;
   hps_stat_type stat;
   logic         req_ready;

   // register file: cube_bits only, word select on paddr[2]
   logic [CUBE_BITS_W-1:0] cube_bits_ff;
   logic [CUBE_BITS_W-1:0] cube_bits_in;
   logic                   csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cube_bits_in = cube_bits_ff;
      if (csr_wr && (paddr[2] == CSR_IDX_CUBE_BITS)) begin
         cube_bits_in = pwdata[CUBE_BITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_bits_ff <= CUBE_BITS_RESET;
      end else begin
         cube_bits_ff <= cube_bits_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_CUBE_BITS) begin
         prdata = CSR_DATA_W'(cube_bits_ff);
      end
   end

   // query controller: idle/run, issues load and step
   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // mask sequencer and output register
   hps_datapath #(
      .MAX_BITS   (MAX_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .cube_bits         (cube_bits_ff),
      .vertex            (req_chan.vertex),
      .probe_limit       (req_chan.probe_limit),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_probe_vertex  (rsp_chan.probe_vertex),
      .rsp_flip_distance (rsp_chan.flip_distance),
      .rsp_last          (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ----- dv/tb_hamming_probe_sequencer.sv -----
`timescale 1ns / 1ps

module tb_hamming_probe_sequencer;
   import hps_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES      = 8;
   localparam int RANDOM_PER_PHASE = 30;
   // cube_bits is register 0, so it sits at byte address 0
   localparam logic [CSR_ADDR_W-1:0] CUBE_BITS_ADDR = CSR_ADDR_W'(4 * CSR_IDX_CUBE_BITS);

   // one query as it goes into the block
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [LIMIT_W-1:0]  probe_limit;
   } query_type;

   // one probe as it comes out
   typedef struct packed {
      logic [VERTEX_W-1:0]   probe_vertex;
      logic [DIST_OUT_W-1:0] flip_distance;
      logic                  last;
   } probe_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // APB-style register port, idle from time zero
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hps_req_if req_chan ();
   hps_rsp_if rsp_chan ();

   hamming_probe_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // queries waiting for the sender, probes waiting for the block
   query_type pending_queries[$];
   probe_type probes_due[$];

   // shadow of cube_bits, as written over the register port
   logic [CUBE_BITS_W-1:0] cube_setting = CUBE_BITS_RESET;

   int queries_issued   = 0;
   int queries_accepted = 0;
   int failures         = 0;
   int cycle_count      = 0;
   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;

   // Next larger value with the same number of set bits (y nonzero).
   function automatic longint unsigned next_weight(input longint unsigned y);
      longint unsigned low;
      longint unsigned r;
      low = y & (~y + 64'd1);
      r   = y + low;
      return (((r ^ y) >> 2) / low) | r;
   endfunction

   // Expected probe sequence of one query under the current cube_bits.
   // Distances go up from zero; within a distance the flip masks come in
   // descending order, produced here as the ascending complements.
   function automatic void enumerate_probes(input query_type q);
      int unsigned     dims;
      int unsigned     limit;
      int unsigned     count;
      int unsigned     d;
      longint unsigned full;
      longint unsigned v;
      longint unsigned y;
      longint unsigned x;
      probe_type       prev;
      probe_type       p;
      bit              have_prev;
      dims = cube_setting;
      if (dims == 0) dims = 1;                          // zero dims acts as one
      if (dims > MAX_BITS_DEF) dims = MAX_BITS_DEF;     // saturate
      limit = q.probe_limit;
      if (limit == 0) limit = 1;                        // zero limit still probes once
      if (limit > MAX_PROBES_DEF) limit = MAX_PROBES_DEF;
      full  = (64'd1 << dims) - 64'd1;
      v     = longint'(q.vertex) & full;                // bits above the cube ignored
      count = 0;
      have_prev = 1'b0;
      prev  = '0;
      for (d = 0; d < dims && count < limit; d++) begin
         y = (64'd1 << (dims - d)) - 64'd1;
         while (y <= full && count < limit) begin
            x = ~y & full;
            p.probe_vertex  = VERTEX_W'(v ^ x);
            p.flip_distance = DIST_OUT_W'(d);
            p.last          = 1'b0;
            if (have_prev) probes_due.insert(probes_due.size(), prev);
            prev      = p;
            have_prev = 1'b1;
            count++;
            y = next_weight(y);
         end
      end
      // the all-ones mask is never reached, so small cubes run out early;
      // either way the final probe carries last
      prev.last = 1'b1;
      probes_due.insert(probes_due.size(), prev);
   endfunction

   // ---------------------------------------------------------------
   // sender: offers the next pending query once the last was taken
   // ---------------------------------------------------------------
   always @(posedge clock) begin : sender
      query_type q;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_queries.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            q = pending_queries.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.vertex      <= q.vertex;
            req_chan.probe_limit <= q.probe_limit;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure on the probe channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // monitor: checks each probe against the oldest expectation, then
   // predicts the probes of any query taken at this edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      probe_type want;
      query_type q;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (probes_due.size() == 0) begin
               $error("unexpected probe: probe_vertex %h flip_distance %0d last %0b",
                      rsp_chan.probe_vertex, rsp_chan.flip_distance, rsp_chan.last);
               failures++;
            end else begin
               want = probes_due.pop_front();
               if (rsp_chan.probe_vertex !== want.probe_vertex) begin
                  $error("probe_vertex: expected %h, got %h",
                         want.probe_vertex, rsp_chan.probe_vertex);
                  failures++;
               end
               if (rsp_chan.flip_distance !== want.flip_distance) begin
                  $error("flip_distance: expected %0d, got %0d",
                         want.flip_distance, rsp_chan.flip_distance);
                  failures++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_chan.last);
                  failures++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            q.vertex      = req_chan.vertex;
            q.probe_limit = req_chan.probe_limit;
            enumerate_probes(q);
            queries_accepted++;
         end
      end
   end

   // hard stop
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_query(input logic [VERTEX_W-1:0] vertex,
                              input logic [LIMIT_W-1:0] probe_limit);
      query_type q;
      q.vertex      = vertex;
      q.probe_limit = probe_limit;
      pending_queries.insert(pending_queries.size(), q);
      queries_issued++;
   endtask

   // mostly in-range limits, some above the saturation point
   task automatic queue_random_query();
      logic [LIMIT_W-1:0] limit;
      if ($urandom_range(0, 99) < 12)
         limit = LIMIT_W'($urandom_range(MAX_PROBES_DEF + 1, 127));
      else
         limit = LIMIT_W'($urandom_range(0, MAX_PROBES_DEF));
      queue_query(VERTEX_W'($urandom_range(0, 65535)), limit);
   endtask

   // every query taken and every probe seen, then a short settle
   task automatic wait_idle();
      while (queries_accepted != queries_issued || probes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup, then access until pready; junk above the field
   task automatic write_cube_bits(input logic [CUBE_BITS_W-1:0] dims);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = CSR_DATA_W'($urandom());
      wdata[CUBE_BITS_W-1:0] = dims;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CUBE_BITS_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cube_setting = dims;
   endtask

   // APB read of cube_bits, compared with the shadow copy
   task automatic check_cube_bits();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CUBE_BITS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CUBE_BITS_W-1:0] !== cube_setting) begin
         $error("cube_bits: expected %0d, got %0d", cube_setting,
                prdata[CUBE_BITS_W-1:0]);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      int unsigned cube_plan[PHASES];
      int phase;
      int n;
      logic [CUBE_BITS_W-1:0] dims;

      // cube sizes per phase: full, one, zero (acts as one), over the top
      // (saturates), tiny cubes where distances run out, a random one, full
      cube_plan = '{16, 1, 0, 31, 2, 3, 0, 16};

      req_chan.valid       = 1'b0;
      req_chan.vertex      = '0;
      req_chan.probe_limit = '0;
      rsp_chan.ready       = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cube_bits as it comes out of reset
      check_cube_bits();

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         dims = (phase == 6) ? CUBE_BITS_W'($urandom_range(1, MAX_BITS_DEF))
                             : CUBE_BITS_W'(cube_plan[phase]);
         write_cube_bits(dims);
         check_cube_bits();

         // idling mix: none, sender gaps, receiver stalls, both
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 55;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 55;
            end
            default: begin
               sender_idle_pct    = 33;
               receiver_stall_pct = 33;
            end
         endcase

         if (phase == 0) begin
            // field extremes and limit edges on the full cube
            queue_query(16'h0000, 7'd0);
            queue_query(16'hFFFF, 7'd1);
            queue_query(16'hAAAA, 7'd2);
            queue_query(16'h5555, 7'd16);
            queue_query(16'h8000, 7'd17);
            queue_query(16'h0001, 7'd63);
            queue_query(16'h7FFF, 7'd64);
            queue_query(16'hFFFF, 7'd65);
            queue_query(16'h1234, 7'd127);
            queue_query(16'h0000, 7'd127);
         end
         // each cube size: the largest limit (runs out on small cubes), and zero limit
         queue_query(16'hFFFF, 7'd127);
         queue_query(VERTEX_W'($urandom_range(0, 65535)), 7'd0);

         for (n = 0; n < RANDOM_PER_PHASE; n++)
            queue_random_query();
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
